// ===== hw/rtl/nbht_pkg.sv =====
// shared types and constants for the normalized block hadamard transform
package nbht_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int K_W        = 3;
	localparam int H_W        = K_W - 1;
	localparam int COEF_W     = 18;
	localparam int FRAC_SH    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam int SAT_MAX    = 32767;
	localparam int SAT_MIN    = -32768;

	localparam logic signed [COEF_W-1:0] INV_SQRT2_Q16 = 18'sd46341;
	localparam logic signed [COEF_W-1:0] UNITY_Q16     = 18'sd65536;

	localparam logic [K_W-1:0] RESET_LOG2 = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_ENABLE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_LOG2   = 1'b1;

	typedef struct packed {
		logic vld;
		logic last;
		logic pass;
	} nbht_ctl_t;

endpackage

// ===== hw/rtl/nbht_core.sv =====
// block store with fill, butterfly sequencer and ordered read-out
module nbht_core #(
	parameter int MAX_BLOCK_LOG2 = 6
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         accept,
	input  logic                                         block_mode,
	input  logic                                         cfg_clear,
	input  logic [nbht_pkg::K_W-1:0]                     k,
	input  logic signed [nbht_pkg::SAMPLE_W-1:0]         sample_in,
	output logic                                         busy,
	output nbht_pkg::nbht_ctl_t                          ctl,
	output logic signed [nbht_pkg::SAMPLE_W+MAX_BLOCK_LOG2-1:0] val
);
	import nbht_pkg::*;

	localparam int ADDR_W = MAX_BLOCK_LOG2;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int DATA_W = SAMPLE_W + MAX_BLOCK_LOG2;

	typedef enum logic [1:0] {S_FILL, S_BFLY, S_OUT} state_t;

	state_t                     state_q;
	logic [ADDR_W:0]            fill_q;
	logic [K_W-1:0]             s_q;
	logic [ADDR_W-1:0]          p_q;
	logic                       ph_q;
	logic                       done_q;
	logic                       pend_q;
	logic [ADDR_W-1:0]          out_idx_q;
	logic [ADDR_W-1:0]          a_addr_q;
	logic [ADDR_W-1:0]          b_addr_q;
	logic [ADDR_W-1:0]          bw_addr_q;
	logic signed [DATA_W-1:0]   diff_q;
	logic signed [DATA_W-1:0]   rd_a_q;
	logic signed [DATA_W-1:0]   rd_b_q;
	nbht_ctl_t                  ctl_s1;
	logic signed [SAMPLE_W-1:0] pass_val_s1;

	logic signed [DATA_W-1:0]   mem [DEPTH];

	logic [ADDR_W:0]            n_v;
	logic [ADDR_W-1:0]          n_m1;
	logic [ADDR_W-1:0]          half_m1;
	logic [ADDR_W-1:0]          len_c;
	logic [ADDR_W-1:0]          a_c;
	logic [ADDR_W-1:0]          b_c;
	logic [ADDR_W-1:0]          ra;
	logic signed [DATA_W-1:0]   sum_c;
	logic signed [DATA_W-1:0]   diff_c;
	logic                       last_pair;
	logic                       last_stage;
	logic                       we;
	logic [ADDR_W-1:0]          wa;
	logic signed [DATA_W-1:0]   wd;

	assign n_v        = (ADDR_W+1)'(1) << k;
	assign n_m1       = ADDR_W'(n_v - 1'b1);
	assign half_m1    = ADDR_W'((n_v >> 1) - 1'b1);
	assign len_c      = ADDR_W'(1) << s_q;
	assign a_c        = ((p_q >> s_q) << (s_q + 1'b1)) | (p_q & (len_c - 1'b1));
	assign b_c        = a_c | len_c;
	assign sum_c      = rd_a_q + rd_b_q;
	assign diff_c     = rd_a_q - rd_b_q;
	assign last_pair  = (p_q == half_m1);
	assign last_stage = (s_q == k - K_W'(1));
	assign ra         = (state_q == S_OUT) ? out_idx_q : a_c;

	always_comb begin
		we = 1'b0;
		wa = fill_q[ADDR_W-1:0];
		wd = DATA_W'(sample_in);
		unique case (state_q)
			S_FILL: begin
				we = accept && block_mode;
			end
			S_BFLY: begin
				if (ph_q) begin
					we = 1'b1;
					wa = a_addr_q;
					wd = sum_c;
				end else begin
					we = pend_q;
					wa = bw_addr_q;
					wd = diff_q;
				end
			end
			S_OUT: begin
				we = 1'b0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// store, two registered read ports with write forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_q <= (we && wa == ra) ? wd : mem[ra];
		rd_b_q <= (we && wa == b_c) ? wd : mem[b_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_FILL;
			fill_q    <= '0;
			s_q       <= '0;
			p_q       <= '0;
			ph_q      <= 1'b0;
			done_q    <= 1'b0;
			pend_q    <= 1'b0;
			out_idx_q <= '0;
			ctl_s1    <= '0;
		end else begin
			ctl_s1.vld <= 1'b0;
			unique case (state_q)
				S_FILL: begin
					if (accept) begin
						if (!block_mode) begin
							ctl_s1.vld  <= 1'b1;
							ctl_s1.last <= 1'b1;
							ctl_s1.pass <= 1'b1;
						end else if (fill_q + 1'b1 == n_v) begin
							fill_q  <= '0;
							state_q <= S_BFLY;
							s_q     <= '0;
							p_q     <= '0;
							ph_q    <= 1'b0;
							done_q  <= 1'b0;
							pend_q  <= 1'b0;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				S_BFLY: begin
					if (!ph_q) begin
						pend_q <= 1'b0;
						if (done_q) begin
							state_q   <= S_OUT;
							out_idx_q <= '0;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						pend_q <= 1'b1;
						ph_q   <= 1'b0;
						if (last_pair) begin
							p_q <= '0;
							if (last_stage) begin
								done_q <= 1'b1;
							end else begin
								s_q <= s_q + 1'b1;
							end
						end else begin
							p_q <= p_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					ctl_s1.vld  <= 1'b1;
					ctl_s1.last <= (out_idx_q == n_m1);
					ctl_s1.pass <= 1'b0;
					if (out_idx_q == n_m1) begin
						state_q <= S_FILL;
					end else begin
						out_idx_q <= out_idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_FILL;
				end
			endcase
			if (cfg_clear) begin
				fill_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BFLY && !ph_q) begin
			a_addr_q <= a_c;
			b_addr_q <= b_c;
		end
		if (state_q == S_BFLY && ph_q) begin
			bw_addr_q <= b_addr_q;
			diff_q    <= diff_c;
		end
		if (state_q == S_FILL && accept) begin
			pass_val_s1 <= sample_in;
		end
	end

	assign busy = (state_q != S_FILL);
	assign ctl  = ctl_s1;
	assign val  = ctl_s1.pass ? DATA_W'(pass_val_s1) : rd_a_q;

	a_no_write_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> !we)
		else $error("store written during read-out");

	a_diff_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BFLY && ph_q) |=> (pend_q && !ph_q))
		else $error("difference write not queued after butterfly");

	a_final_b_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BFLY && done_q && !ph_q) |-> (we && wa == bw_addr_q))
		else $error("last butterfly difference not written before read-out");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_idx_q == n_m1) |=>
		(state_q == S_FILL && ctl_s1.vld && ctl_s1.last))
		else $error("block end not marked on final beat");

endmodule

// ===== hw/rtl/nbht_scale.sv =====
// normalization multiply, rounding and saturation pipeline
module nbht_scale #(
	parameter int MAX_BLOCK_LOG2 = 6
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  nbht_pkg::nbht_ctl_t                          ctl,
	input  logic signed [nbht_pkg::SAMPLE_W+MAX_BLOCK_LOG2-1:0] val,
	input  logic [nbht_pkg::K_W-1:0]                     k,
	output logic                                         strobe,
	output logic signed [nbht_pkg::SAMPLE_W-1:0]         sample_out,
	output logic                                         last,
	output logic                                         sat
);
	import nbht_pkg::*;

	localparam int DATA_W = SAMPLE_W + MAX_BLOCK_LOG2;
	localparam int PROD_W = DATA_W + COEF_W;
	localparam int SUM_W  = PROD_W + 1;

	logic                       odd_c;
	logic signed [COEF_W-1:0]   coef_c;
	logic [H_W-1:0]             h_c;
	logic signed [PROD_W-1:0]   prod_c;

	logic                       vld_s2;
	logic                       last_s2;
	logic [H_W-1:0]             h_s2;
	logic signed [PROD_W-1:0]   prod_s2;

	logic signed [SUM_W-1:0]    rnd_c;
	logic signed [SUM_W-1:0]    sh_c;
	logic                       hi_c;
	logic                       lo_c;

	logic                       strobe_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       last_q;
	logic                       sat_q;

	assign odd_c  = !ctl.pass && k[0];
	assign coef_c = odd_c ? INV_SQRT2_Q16 : UNITY_Q16;
	assign h_c    = ctl.pass ? '0 : k[K_W-1:1];
	assign prod_c = val * coef_c;

	assign rnd_c = SUM_W'(prod_s2) + (SUM_W'(1) << (FRAC_SH - 1 + h_s2));
	assign sh_c  = rnd_c >>> (FRAC_SH + h_s2);
	assign hi_c  = sh_c > SUM_W'(SAT_MAX);
	assign lo_c  = sh_c < SUM_W'(SAT_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			vld_s2   <= ctl.vld;
			strobe_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s2  <= ctl.last;
		h_s2     <= h_c;
		prod_s2  <= prod_c;
		last_q   <= last_s2;
		sat_q    <= hi_c || lo_c;
		if (hi_c) begin
			sample_q <= SAMPLE_W'(SAT_MAX);
		end else if (lo_c) begin
			sample_q <= SAMPLE_W'(SAT_MIN);
		end else begin
			sample_q <= sh_c[SAMPLE_W-1:0];
		end
	end

	assign strobe     = strobe_q;
	assign sample_out = sample_q;
	assign last       = last_q;
	assign sat        = sat_q;

endmodule

// ===== hw/rtl/normalized_block_hadamard_transform.sv =====
// top level: config registers, block store core and output scaling
// pass-through (disabled, or block length one): a sample is taken every cycle and its
//   result strobes behind the core control, scale stage-two and output registers
// block of n = 2^k: samples are taken one a cycle, then busy stays high through the butterfly
//   stages (one store write port) and the read-out of all n results; results follow one a cycle,
//   behind the reads through the read, scale stage-two and output registers; results cannot
//   be stalled
// reset clears the config to disabled with k = 5 and empties the block; store contents
//   stay undefined and get no clearing pass
module normalized_block_hadamard_transform #(
	parameter int MAX_BLOCK_LOG2 = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [nbht_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                  cfg_we,
	input  logic [nbht_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nbht_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  result_strobe,
	output logic signed [nbht_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                  block_last,
	output logic                                  saturated
);
	import nbht_pkg::*;

	localparam int DATA_W = SAMPLE_W + MAX_BLOCK_LOG2;

	logic                     rotate_enable_q;
	logic [K_W-1:0]           rotate_log2_q;
	logic [K_W-1:0]           k_eff;
	logic                     block_mode;
	logic                     accept;
	nbht_ctl_t                ctl;
	logic signed [DATA_W-1:0] val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotate_enable_q <= 1'b0;
			rotate_log2_q   <= RESET_LOG2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROTATE_ENABLE: rotate_enable_q <= cfg_data[0];
				CFG_ROTATE_LOG2:   rotate_log2_q   <= cfg_data;
				default:           rotate_log2_q   <= rotate_log2_q;
			endcase
		end
	end

	assign k_eff      = (rotate_log2_q > K_W'(MAX_BLOCK_LOG2)) ? K_W'(MAX_BLOCK_LOG2)
	                                                           : rotate_log2_q;
	assign block_mode = rotate_enable_q && (k_eff != '0);
	assign accept     = start && !busy;

	nbht_core #(
		.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.block_mode (block_mode),
		.cfg_clear  (cfg_we),
		.k          (k_eff),
		.sample_in  (sample_in),
		.busy       (busy),
		.ctl        (ctl),
		.val        (val)
	);

	nbht_scale #(
		.MAX_BLOCK_LOG2(MAX_BLOCK_LOG2)
	) u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.val        (val),
		.k          (k_eff),
		.strobe     (result_strobe),
		.sample_out (sample_out),
		.last       (block_last),
		.sat        (saturated)
	);

endmodule
